@@ design/tcq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared widths, types and codes for the two-class ticket queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TICKET_BITS = 16;

	localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;
	localparam int AGE_W      = 8;
	localparam int STREAK_W   = 4;
	localparam int STATUS_W   = 3;
	localparam int OUT_TKT_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [TICKET_BITS-1:0] ticket_t;
	typedef logic [AGE_W-1:0]       age_t;
	typedef logic [STREAK_W-1:0]    streak_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [OUT_TKT_W-1:0]   out_ticket_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam streak_t STREAK_MAX = '1;

	localparam age_t    THRESHOLD_RST    = AGE_W'(60);
	localparam streak_t STREAK_LIMIT_RST = STREAK_W'(3);

	localparam cfg_idx_t REG_THRESHOLD    = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_STREAK_LIMIT = CFG_IDX_W'(1);

	localparam status_t ST_ISSUED_PRIO = STATUS_W'(0);
	localparam status_t ST_ISSUED_REG  = STATUS_W'(1);
	localparam status_t ST_INVALID     = STATUS_W'(2);
	localparam status_t ST_FULL        = STATUS_W'(3);
	localparam status_t ST_SERVED_PRIO = STATUS_W'(4);
	localparam status_t ST_SERVED_REG  = STATUS_W'(5);
	localparam status_t ST_NONE        = STATUS_W'(6);

	// circular increment of a read pointer
	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// write slot: head + count, wrapped at the queue depth
	function automatic ptr_t tail_of(input ptr_t head, input cnt_t count);
		logic [SUM_W-1:0] sum;
		ptr_t r;
		sum = SUM_W'(head) + SUM_W'(count);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			r = PTR_W'(sum - SUM_W'(QUEUE_DEPTH));
		end else begin
			r = PTR_W'(sum);
		end
		return r;
	endfunction

	// low bits of a ticket as reported on the result channel
	function automatic out_ticket_t ticket_out(input ticket_t t);
		logic [31:0] wide;
		wide = 32'(t);
		return wide[OUT_TKT_W-1:0];
	endfunction

endpackage

@@ design/tcq_req_if.sv @@
// ----------------------------------------------------------------------------
// tcq_req_if
// Request channel: issue or call items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcq_req_if;
	import tcq_pkg::*;

	logic valid;
	logic ready;
	logic kind;
	age_t age;

	modport source (output valid, output kind, output age, input ready);
	modport sink   (input valid, input kind, input age, output ready);
endinterface

@@ design/tcq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tcq_rsp_if
// Result channel: status and ticket with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcq_rsp_if;
	import tcq_pkg::*;

	logic        valid;
	logic        ready;
	status_t     status;
	out_ticket_t ticket;

	modport source (output valid, output status, output ticket, input ready);
	modport sink   (input valid, input status, input ticket, output ready);
endinterface

@@ design/two_class_queue_starvation_limit_core.sv @@
// ----------------------------------------------------------------------------
// two_class_queue_starvation_limit_core
// Issue results, and results of calls with nothing waiting, go straight into
//   the result register; a call that pops a ticket first passes the synchronous
//   memory read (S_READ). One issue per cycle while the result register is free;
//   no new item is taken in S_READ. arst_n clears counters, pointers and config
//   to their defaults; queue memories are not cleared (only written slots read).
// ----------------------------------------------------------------------------
module two_class_queue_starvation_limit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  tcq_pkg::cfg_idx_t  cfg_index,
	input  tcq_pkg::cfg_data_t cfg_data,
	tcq_req_if.sink            req,
	tcq_rsp_if.source          rsp
);
	import tcq_pkg::*;

	// sequencer: idle, or waiting on the memory read of a call
	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;

	// config registers
	age_t    threshold_q;
	streak_t streak_limit_q;

	// queue bookkeeping
	ptr_t    prio_head_q;
	cnt_t    prio_count_q;
	ptr_t    reg_head_q;
	cnt_t    reg_count_q;
	streak_t streak_q;
	ticket_t next_ticket_q;

	// queue memories, one synchronous read port each
	ticket_t prio_mem [QUEUE_DEPTH];
	ticket_t reg_mem  [QUEUE_DEPTH];
	ticket_t prio_rd_q;
	ticket_t reg_rd_q;
	logic    serve_reg_s1;   // which memory the pending call reads

	// result register
	logic        out_valid_q;
	status_t     out_status_q;
	out_ticket_t out_ticket_q;

	logic    out_free;
	logic    accept;
	logic    is_issue;
	logic    is_call;
	logic    age_zero;
	logic    to_prio;
	logic    full;
	logic    push_ok;
	logic    prio_we;
	logic    reg_we;
	ptr_t    prio_tail;
	ptr_t    reg_tail;
	logic    none_waiting;
	logic    serve_reg;
	logic    pop_prio;
	logic    pop_reg;
	logic    load_now;
	status_t now_status;
	ticket_t now_ticket;

	// ---------------------------------------------------------------
	// Handshake. A new item is taken only in idle and when the result
	// register is empty or being drained in this cycle.
	// ---------------------------------------------------------------
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign is_issue  = accept && !req.kind;
	assign is_call   = accept && req.kind;

	// ---------------------------------------------------------------
	// Issue path: route by age, refuse on zero age or a full line.
	// ---------------------------------------------------------------
	assign age_zero  = (req.age == '0);
	assign to_prio   = (req.age >= threshold_q);
	assign full      = to_prio ? (prio_count_q == CNT_W'(QUEUE_DEPTH))
	                           : (reg_count_q == CNT_W'(QUEUE_DEPTH));
	assign push_ok   = is_issue && !age_zero && !full;
	assign prio_we   = push_ok && to_prio;
	assign reg_we    = push_ok && !to_prio;
	assign prio_tail = tail_of(prio_head_q, prio_count_q);
	assign reg_tail  = tail_of(reg_head_q, reg_count_q);

	// ---------------------------------------------------------------
	// Call path: priority first, unless the streak has reached its
	// limit and a regular ticket waits, or the priority line is empty.
	// ---------------------------------------------------------------
	assign none_waiting = (prio_count_q == '0) && (reg_count_q == '0);
	assign serve_reg    = (reg_count_q != '0) &&
	                      ((streak_q >= streak_limit_q) || (prio_count_q == '0));
	assign pop_reg      = is_call && serve_reg;
	assign pop_prio     = is_call && !none_waiting && !serve_reg;

	// results that are known in the accept cycle
	assign load_now = is_issue || (is_call && none_waiting);

	always_comb begin
		now_status = ST_NONE;
		now_ticket = '0;
		if (!req.kind) begin
			if (age_zero) begin
				now_status = ST_INVALID;
			end else if (full) begin
				now_status = ST_FULL;
			end else begin
				now_status = to_prio ? ST_ISSUED_PRIO : ST_ISSUED_REG;
				now_ticket = next_ticket_q;
			end
		end
	end

	// ---------------------------------------------------------------
	// Memories: write at the tail on issue, read at the head on call.
	// The read data register holds the entry at the pre-pop head.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (prio_we) begin
			prio_mem[prio_tail] <= next_ticket_q;
		end
		if (pop_prio) begin
			prio_rd_q <= prio_mem[prio_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (reg_we) begin
			reg_mem[reg_tail] <= next_ticket_q;
		end
		if (pop_reg) begin
			reg_rd_q <= reg_mem[reg_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (is_call) begin
			serve_reg_s1 <= serve_reg;
		end
	end

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			threshold_q    <= THRESHOLD_RST;
			streak_limit_q <= STREAK_LIMIT_RST;
			prio_head_q    <= '0;
			prio_count_q   <= '0;
			reg_head_q     <= '0;
			reg_count_q    <= '0;
			streak_q       <= '0;
			next_ticket_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD:    threshold_q    <= AGE_W'(cfg_data);
					REG_STREAK_LIMIT: streak_limit_q <= STREAK_W'(cfg_data);
					default:          ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (pop_prio || pop_reg) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (push_ok) begin
				next_ticket_q <= next_ticket_q + TICKET_BITS'(1);
			end
			if (prio_we) begin
				prio_count_q <= prio_count_q + CNT_W'(1);
			end
			if (reg_we) begin
				reg_count_q <= reg_count_q + CNT_W'(1);
			end

			if (pop_prio) begin
				prio_head_q  <= ptr_inc(prio_head_q);
				prio_count_q <= prio_count_q - CNT_W'(1);
				if (streak_q != STREAK_MAX) begin
					streak_q <= streak_q + STREAK_W'(1);
				end
			end
			if (pop_reg) begin
				reg_head_q  <= ptr_inc(reg_head_q);
				reg_count_q <= reg_count_q - CNT_W'(1);
				streak_q    <= '0;
			end

			if (load_now || (state_q == S_READ)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_now) begin
			out_status_q <= now_status;
			out_ticket_q <= ticket_out(now_ticket);
		end else if (state_q == S_READ) begin
			out_status_q <= serve_reg_s1 ? ST_SERVED_REG : ST_SERVED_PRIO;
			out_ticket_q <= ticket_out(serve_reg_s1 ? reg_rd_q : prio_rd_q);
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.ticket = out_ticket_q;

endmodule
